### rtl/aisfx_pkg.sv
// Shared types, constants and de-armouring function for the AIS field extractor.
`timescale 1ns / 1ps

package aisfx_pkg;

  // Fixed field widths
  localparam int CODE_W  = 8;
  localparam int START_W = 11;
  localparam int LEN_W   = 6;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int DIG_W   = 6;             // bits per payload character
  localparam int CHAR_W  = DIG_W + 1;     // stored character: flag + value
  localparam int INV_BIT = DIG_W;         // invalid flag position
  localparam int SHAMT_W = $clog2(VAL_W);

  // Longest field a request may ask for
  localparam int MAX_FIELD_BITS = 32;

  // Armour code range and the gap in the 6-bit ASCII mapping
  localparam logic [CODE_W-1:0] ARMOUR_LOW  = 8'd48;
  localparam logic [CODE_W-1:0] ARMOUR_HIGH = 8'd119;
  localparam logic [CODE_W-1:0] ARMOUR_GAP  = 8'd40;
  localparam logic [CODE_W-1:0] ARMOUR_SKIP = 8'd8;

  // Reciprocal of 3 for (start_bit / 2) / 3, exact over the 10-bit range
  localparam logic [9:0] RECIP_3     = 10'd683;
  localparam int         RECIP_SHIFT = 11;

  // Operation codes
  localparam logic MODE_APPEND  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [STAT_W-1:0] ST_PAST_END = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_CHAR = 2'd3;

  typedef struct packed {
    logic               mode;
    logic               first_char;
    logic [CODE_W-1:0]  char_code;
    logic [START_W-1:0] start_bit;
    logic [LEN_W-1:0]   bit_count;
    logic               is_signed;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  field_value;
    logic [STAT_W-1:0] status;
  } rsp_t;

  // Armoured ASCII to stored character: invalid flag, or 6-bit value
  function automatic logic [CHAR_W-1:0] dearmour(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] v;
    logic [CHAR_W-1:0] r;
    v = code - ARMOUR_LOW;
    if (v > ARMOUR_GAP) begin
      v = v - ARMOUR_SKIP;
    end
    if (code < ARMOUR_LOW || code > ARMOUR_HIGH) begin
      r = CHAR_W'(1) << INV_BIT;
    end else begin
      r = {1'b0, v[DIG_W-1:0]};
    end
    return r;
  endfunction

endpackage

### rtl/aisfx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module aisfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ais_payload_field_extractor_core.sv
// AIS payload store and character-serial field extractor, top level.
// Append: no result; the next item is taken the cycle after.
// Field request: divide, setup, read and done steps in turn; the payload store
//   delivers one character per cycle. Length or range errors skip to the done step.
// One item in flight; a waiting result does not block a following append.
// Reset clears the character count and control; the store itself is not cleared.
`timescale 1ns / 1ps

module ais_payload_field_extractor_core #(
  parameter int MAX_CHARS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  aisfx_pkg::req_t       req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output aisfx_pkg::rsp_t       rsp
);

  localparam int AW   = $clog2(MAX_CHARS);
  localparam int CW   = $clog2(MAX_CHARS + 1);
  localparam int CMPW = (CW + 3 > aisfx_pkg::START_W + 1) ? CW + 3 : aisfx_pkg::START_W + 1;
  localparam int QW   = 9;   // floor(start_bit / 6) fits in 9 bits

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                      state;
  logic [CW-1:0]                   cnt;
  logic [aisfx_pkg::START_W-1:0]   start;
  logic [aisfx_pkg::LEN_W-1:0]     len;
  logic                            sgn;
  logic [QW-1:0]                   q;
  logic [2:0]                      off;
  logic [AW-1:0]                   rd_addr;
  logic                            rd_pend;
  logic [aisfx_pkg::LEN_W-1:0]     rem;
  logic [aisfx_pkg::VAL_W-1:0]     acc;
  logic                            lead;
  logic                            sgnbit;
  logic [aisfx_pkg::STAT_W-1:0]    status;

  // Store ports
  logic                            we;
  logic [AW-1:0]                   waddr;
  logic [aisfx_pkg::CHAR_W-1:0]    wdata;
  logic [aisfx_pkg::CHAR_W-1:0]    rdata;

  // Datapath
  logic [19:0]                     prod;
  logic [QW-1:0]                   q_w;
  logic [aisfx_pkg::START_W-1:0]   q6;
  logic [aisfx_pkg::START_W-1:0]   off_full;
  logic [CMPW-1:0]                 fend;
  logic [CMPW-1:0]                 limit;
  logic                            bad_len;
  logic                            past_end;
  logic [2:0]                      avail;
  logic [2:0]                      take;
  logic [aisfx_pkg::DIG_W-1:0]     shl;
  logic [aisfx_pkg::DIG_W-1:0]     chunk;
  logic [aisfx_pkg::VAL_W-1:0]     acc_shift;
  logic [aisfx_pkg::VAL_W-1:0]     ext_mask;
  logic [aisfx_pkg::VAL_W-1:0]     result;

  assign req_stall = (state != S_IDLE);

  // Append path: de-armour and write at the fill position
  always_comb begin
    we    = (state == S_IDLE) && req_valid && (req.mode == aisfx_pkg::MODE_APPEND) &&
            (req.first_char || (cnt < CW'(MAX_CHARS)));
    waddr = req.first_char ? '0 : AW'(cnt);
    wdata = aisfx_pkg::dearmour(req.char_code);
  end

  // Character index of the first bit by reciprocal multiply; range and length checks
  always_comb begin
    prod     = 20'(start[aisfx_pkg::START_W-1:1]) * 20'(aisfx_pkg::RECIP_3);
    q_w      = prod[aisfx_pkg::RECIP_SHIFT +: QW];
    q6       = (aisfx_pkg::START_W'(q) << 2) + (aisfx_pkg::START_W'(q) << 1);
    off_full = start - q6;
    fend     = CMPW'(start) + CMPW'(len);
    limit    = (CMPW'(cnt) << 2) + (CMPW'(cnt) << 1);
    bad_len  = (len == '0) || ({1'b0, len} > 7'(aisfx_pkg::MAX_FIELD_BITS));
    past_end = fend > limit;
  end

  // One character per cycle: take up to six bits, MSB first
  always_comb begin
    avail     = 3'(aisfx_pkg::DIG_W) - off;
    take      = (rem < aisfx_pkg::LEN_W'(avail)) ? rem[2:0] : avail;
    shl       = rdata[aisfx_pkg::DIG_W-1:0] << off;
    chunk     = shl >> (3'(aisfx_pkg::DIG_W) - take);
    acc_shift = (acc << take) | aisfx_pkg::VAL_W'(chunk);
  end

  // Final value: zero on error status, sign extension for fields shorter than the output word
  always_comb begin
    ext_mask = {aisfx_pkg::VAL_W{1'b1}} << len[aisfx_pkg::SHAMT_W-1:0];
    if (status != aisfx_pkg::ST_OK) begin
      result = '0;
    end else if (sgn && sgnbit && (len < aisfx_pkg::LEN_W'(aisfx_pkg::VAL_W))) begin
      result = acc | ext_mask;
    end else begin
      result = acc;
    end
  end

  aisfx_ram #(
    .WIDTH(aisfx_pkg::CHAR_W),
    .DEPTH(MAX_CHARS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      // the done step owns the result flag while it waits
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.mode == aisfx_pkg::MODE_APPEND) begin
              if (we) begin
                cnt <= req.first_char ? CW'(1) : cnt + CW'(1);
              end
            end else begin
              start <= req.start_bit;
              len   <= req.bit_count;
              sgn   <= req.is_signed;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          q <= q_w;
          if (bad_len) begin
            status <= aisfx_pkg::ST_BAD_LEN;
            state  <= S_DONE;
          end else if (past_end) begin
            status <= aisfx_pkg::ST_PAST_END;
            state  <= S_DONE;
          end else begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          off     <= off_full[2:0];
          rd_addr <= AW'(q);
          rem     <= len;
          acc     <= '0;
          lead    <= 1'b1;
          status  <= aisfx_pkg::ST_OK;
          state   <= S_READ;
        end
        S_READ: begin
          rd_addr <= rd_addr + AW'(1);
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else if (rdata[aisfx_pkg::INV_BIT]) begin
            status  <= aisfx_pkg::ST_BAD_CHAR;
            rd_pend <= 1'b0;
            state   <= S_DONE;
          end else begin
            acc  <= acc_shift;
            rem  <= rem - aisfx_pkg::LEN_W'(take);
            off  <= '0;
            lead <= 1'b0;
            if (lead) begin
              sgnbit <= shl[aisfx_pkg::DIG_W-1];
            end
            if (rem == aisfx_pkg::LEN_W'(take)) begin
              rd_pend <= 1'b0;
              state   <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            rsp.field_value <= result;
            rsp.status      <= status;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(MAX_CHARS))
    else $error("character count beyond store depth");

  assert property (@(posedge clk) disable iff (rst) $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done step");

  assert property (@(posedge clk) disable iff (rst) (state == S_READ) |-> (rem != '0))
    else $error("reading with no field bits left");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != aisfx_pkg::ST_OK) |-> (rsp.field_value == '0))
    else $error("nonzero value on error status");

endmodule

### sim/tb_top.sv
// Testbench for the AIS payload field extractor: randomized appends and checked field requests.
`timescale 1ns / 1ps

module tb_top;

  localparam int CHAR_SLOTS = 256;

  // Pending item with an optional hold-off until all fields are back
  typedef struct {
    aisfx_pkg::req_t item;
    bit              drain;
  } pend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  aisfx_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  aisfx_pkg::rsp_t rsp;

  // Stimulus and prediction state
  pend_t                        pending[$];
  aisfx_pkg::rsp_t              field_due[$];
  logic [aisfx_pkg::CHAR_W-1:0] shadow_chars[CHAR_SLOTS];
  int                           shadow_count = 0;
  int                           built_count = 0;
  int                           n_built = 0;
  int                           mismatches = 0;
  logic                         req_taken = 1'b0;
  int                           burst_left = 0;
  int                           gap_left = 0;
  logic [15:0]                  stall_pat = '0;
  logic [5:0]                   stall_phase = '0;

  ais_payload_field_extractor_core #(
    .MAX_CHARS(CHAR_SLOTS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Armoured ASCII to stored character
  function automatic logic [aisfx_pkg::CHAR_W-1:0] char_decode(
    input logic [aisfx_pkg::CODE_W-1:0] code
  );
    int v;
    if (code < aisfx_pkg::ARMOUR_LOW || code > aisfx_pkg::ARMOUR_HIGH) begin
      return {1'b1, {aisfx_pkg::DIG_W{1'b0}}};
    end
    v = int'(code) - int'(aisfx_pkg::ARMOUR_LOW);
    if (v > int'(aisfx_pkg::ARMOUR_GAP)) begin
      v = v - int'(aisfx_pkg::ARMOUR_SKIP);
    end
    return {1'b0, v[aisfx_pkg::DIG_W-1:0]};
  endfunction

  // Apply one item to the shadow payload; requests yield the expected field
  task automatic field_model(input aisfx_pkg::req_t it, output bit gives,
                             output aisfx_pkg::rsp_t res);
    logic [63:0]                  acc;
    logic [aisfx_pkg::CHAR_W-1:0] ent;
    int                           len;
    int                           pos;
    int                           i;
    bit                           bad;
    gives = 1'b0;
    res = '0;
    len = int'(it.bit_count);
    if (it.mode == aisfx_pkg::MODE_APPEND) begin
      if (it.first_char) begin
        shadow_count = 0;
      end
      if (shadow_count < CHAR_SLOTS) begin
        shadow_chars[shadow_count] = char_decode(it.char_code);
        shadow_count++;
      end
    end else begin
      gives = 1'b1;
      if (len == 0 || len > aisfx_pkg::MAX_FIELD_BITS) begin
        res.status = aisfx_pkg::ST_BAD_LEN;
      end else if (int'(it.start_bit) + len > aisfx_pkg::DIG_W * shadow_count) begin
        res.status = aisfx_pkg::ST_PAST_END;
      end else begin
        acc = '0;
        bad = 1'b0;
        for (i = 0; i < len; i++) begin
          pos = int'(it.start_bit) + i;
          ent = shadow_chars[pos / aisfx_pkg::DIG_W];
          if (ent[aisfx_pkg::INV_BIT]) begin
            bad = 1'b1;
          end
          acc = {acc[62:0], ent[aisfx_pkg::DIG_W - 1 - (pos % aisfx_pkg::DIG_W)]};
        end
        if (bad) begin
          res.status = aisfx_pkg::ST_BAD_CHAR;
        end else begin
          // sign extension from the field's top bit
          if (it.is_signed && acc[len-1]) begin
            acc = acc | ({64{1'b1}} << len);
          end
          res.status = aisfx_pkg::ST_OK;
          res.field_value = acc[aisfx_pkg::VAL_W-1:0];
        end
      end
    end
  endtask

  // Item builders: unused fields carry random values
  function automatic aisfx_pkg::req_t char_item(input logic first,
                                                input logic [aisfx_pkg::CODE_W-1:0] code);
    aisfx_pkg::req_t it;
    it.mode = aisfx_pkg::MODE_APPEND;
    it.first_char = first;
    it.char_code = code;
    it.start_bit = aisfx_pkg::START_W'($urandom);
    it.bit_count = aisfx_pkg::LEN_W'($urandom);
    it.is_signed = 1'($urandom);
    return it;
  endfunction

  function automatic aisfx_pkg::req_t field_req(input int start, input int len, input logic sgn);
    aisfx_pkg::req_t it;
    it.mode = aisfx_pkg::MODE_EXTRACT;
    it.first_char = 1'($urandom);
    it.char_code = aisfx_pkg::CODE_W'($urandom);
    it.start_bit = aisfx_pkg::START_W'(start);
    it.bit_count = aisfx_pkg::LEN_W'(len);
    it.is_signed = sgn;
    return it;
  endfunction

  // Mostly valid armour codes, sometimes any byte
  function automatic logic [aisfx_pkg::CODE_W-1:0] pick_code();
    if ($urandom_range(0, 15) == 0) begin
      return aisfx_pkg::CODE_W'($urandom_range(0, 255));
    end
    return aisfx_pkg::CODE_W'($urandom_range(int'(aisfx_pkg::ARMOUR_LOW),
                                             int'(aisfx_pkg::ARMOUR_HIGH)));
  endfunction

  // Queue an item and track the payload length the DUT will hold
  task automatic queue_item(input aisfx_pkg::req_t it, input bit drain);
    pend_t p;
    p.item = it;
    p.drain = drain;
    pending.push_back(p);
    n_built++;
    if (it.mode == aisfx_pkg::MODE_APPEND) begin
      if (it.first_char) begin
        built_count = 0;
      end
      if (built_count < CHAR_SLOTS) begin
        built_count++;
      end
    end
  endtask

  // Driver: bursts with random gaps, payload held while stalled
  always @(negedge clk) begin
    logic            nxt_valid;
    aisfx_pkg::req_t nxt_req;
    pend_t           p;
    nxt_valid = req_valid;
    nxt_req = req;
    if (!rst) begin
      if (req_valid && req_taken) begin
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending[0].drain && field_due.size() != 0)) begin
          p = pending.pop_front();
          nxt_req = p.item;
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
          end
        end
      end
    end
    req_valid <= nxt_valid;
    req <= nxt_req;
  end

  // Receiver stall pattern, reshuffled each time the phase counter wraps
  always @(negedge clk) begin
    if (stall_phase == '0) begin
      case ($urandom_range(0, 3))
        0: stall_pat <= '0;
        1: stall_pat <= 16'($urandom);
        2: stall_pat <= 16'($urandom & $urandom);
        default: stall_pat <= 16'($urandom & $urandom & $urandom);
      endcase
    end
    stall_phase <= stall_phase + 6'd1;
    rsp_stall <= stall_pat[stall_phase[3:0]];
  end

  // Monitor: check results in order, predict on each accepted item
  always @(posedge clk) begin
    bit              gives;
    aisfx_pkg::rsp_t res;
    aisfx_pkg::rsp_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        if (field_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected field: value %h status %0d", rsp.field_value, rsp.status);
          end
        end else begin
          want = field_due.pop_front();
          if (rsp.field_value !== want.field_value || rsp.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("field mismatch: expected value %h status %0d, got value %h status %0d",
                       want.field_value, want.status, rsp.field_value, rsp.status);
            end
          end
        end
      end
      if (req_valid && !req_stall) begin
        field_model(req, gives, res);
        if (gives) begin
          field_due.push_back(res);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int  msg_len;
    int  n_req;
    int  k;
    int  len;
    int  bits;
    int  start;
    bit  first;
    bit  full_done;
    full_done = 1'b0;

    // Directed: empty payload, length checks, armour edges, invalid chars
    queue_item(field_req(0, 1, 1'b0), 1'b0);
    queue_item(field_req(0, 0, 1'b0), 1'b0);
    queue_item(char_item(1'b1, 8'd48), 1'b0);
    queue_item(char_item(1'b0, 8'd87), 1'b0);
    queue_item(char_item(1'b0, 8'd88), 1'b0);
    queue_item(char_item(1'b0, 8'd89), 1'b0);
    queue_item(char_item(1'b0, 8'd96), 1'b0);
    queue_item(char_item(1'b0, 8'd119), 1'b0);
    queue_item(field_req(0, 32, 1'b0), 1'b0);
    queue_item(field_req(4, 32, 1'b1), 1'b0);
    queue_item(field_req(35, 1, 1'b1), 1'b0);
    queue_item(field_req(0, 1, 1'b1), 1'b0);
    queue_item(field_req(35, 2, 1'b0), 1'b0);
    queue_item(field_req(0, 33, 1'b0), 1'b0);
    queue_item(field_req(0, 63, 1'b1), 1'b0);
    queue_item(field_req(2047, 32, 1'b0), 1'b1);
    queue_item(char_item(1'b0, 8'd0), 1'b0);
    queue_item(char_item(1'b0, 8'd47), 1'b0);
    queue_item(char_item(1'b0, 8'd120), 1'b0);
    queue_item(char_item(1'b0, 8'd255), 1'b0);
    queue_item(field_req(30, 12, 1'b0), 1'b0);
    queue_item(field_req(34, 3, 1'b1), 1'b0);
    queue_item(char_item(1'b1, 8'd119), 1'b0);
    queue_item(field_req(0, 6, 1'b1), 1'b0);
    queue_item(field_req(1, 6, 1'b0), 1'b0);

    // Random messages followed by field requests
    while (n_built < 825) begin
      if (!full_done && n_built > 300) begin
        msg_len = CHAR_SLOTS + 3;
        full_done = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        msg_len = $urandom_range(17, 90);
      end else begin
        msg_len = $urandom_range(1, 16);
      end
      for (k = 0; k < msg_len; k++) begin
        first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 199) == 0);
        queue_item(char_item(first, pick_code()), 1'b0);
      end
      n_req = $urandom_range(1, 8);
      for (k = 0; k < n_req; k++) begin
        if ($urandom_range(0, 5) == 0) begin
          queue_item(field_req($urandom_range(0, 2047), $urandom_range(0, 63), 1'($urandom)),
                     $urandom_range(0, 49) == 0);
        end else begin
          len = $urandom_range(1, aisfx_pkg::MAX_FIELD_BITS);
          bits = aisfx_pkg::DIG_W * built_count;
          start = (bits >= len) ? $urandom_range(0, bits - len) : 0;
          // just past the payload end
          if ($urandom_range(0, 9) == 0) begin
            start = (bits + 1 > len) ? bits - len + 1 : 0;
          end
          queue_item(field_req(start, len, 1'($urandom)), $urandom_range(0, 49) == 0);
        end
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending.size() != 0 || req_valid) begin
      @(posedge clk);
    end
    while (field_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
